### rtl/ptcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Power trace capture sequencer package
// Shared beat types, configuration record, operation and register codes,
// and the milliwatt to centiwatt conversion.
// ----------------------------------------------------------------------------
package ptcs_pkg;

    localparam int unsigned SAMPLE_COUNT_DEF = 4096;
    localparam logic [18:0] TIME_CAP = 19'd300000;
    localparam logic [15:0] CW_MAX = 16'd65535;
    // Smallest power in milliwatts whose tenth reaches the centiwatt ceiling.
    localparam logic [23:0] MW_SAT = 24'd655350;
    // Reciprocal of ten scaled by 2^23, exact for every quotient below the ceiling.
    localparam logic [19:0] RECIP_TEN = 20'd838861;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_ON_BUSY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_DURATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RING_MODE = 3'd4;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_BUSY  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [31:0]        now_ms;
        logic signed [23:0] power_mw;
        logic               busy_now;
    } in_beat_t;

    typedef struct packed {
        logic        write_valid;
        logic [11:0] write_index;
        logic [15:0] sample_centiwatts;
        logic [12:0] next_index;
        logic        wrapped;
        logic        capturing;
    } out_beat_t;

    typedef struct packed {
        logic [18:0] start_delay;
        logic        start_on_busy;
        logic [18:0] capture_duration;
        logic [15:0] sample_divisor;
        logic        ring_mode;
    } cfg_t;

    // Floor of mW / 10, zero for non-positive power, clamped to the ceiling.
    function automatic logic [15:0] to_centiwatts(input logic signed [23:0] mw);
        logic [39:0] prod;
        logic [15:0] cw;
        prod = {20'd0, mw[19:0]} * {20'd0, RECIP_TEN};
        if (mw[23] || (mw == 24'sd0))
        begin
            cw = 16'd0;
        end
        else if (unsigned'(mw) >= MW_SAT)
        begin
            cw = CW_MAX;
        end
        else
        begin
            cw = prod[38:23];
        end
        return cw;
    endfunction

    function automatic logic [18:0] sat_time(input logic [18:0] v);
        return (v > TIME_CAP) ? TIME_CAP : v;
    endfunction

endpackage
`default_nettype wire

### rtl/ptcs_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Power trace capture sequencer core
// Holds the capture state and turns one operation beat into one result beat.
// ----------------------------------------------------------------------------
module ptcs_core
    import ptcs_pkg::*;
#(
    parameter int unsigned SAMPLE_COUNT = SAMPLE_COUNT_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire in_beat_t  beat,
    input  wire cfg_t      cfg,
    output out_beat_t      result
);

    localparam int unsigned SLOT_W = $clog2(SAMPLE_COUNT + 1);
    localparam logic [SLOT_W-1:0] SLOT_FULL = SLOT_W'(SAMPLE_COUNT);

    logic              enabled_reg, enabled_next;
    logic [15:0]       phase_reg, phase_next;
    logic [31:0]       not_before_reg, not_before_next;
    logic              wait_busy_reg, wait_busy_next;
    logic              busy_seen_reg, busy_seen_next;
    logic              reset_on_busy_reg, reset_on_busy_next;
    logic [18:0]       duration_reg, duration_next;
    logic [31:0]       deadline_reg, deadline_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              wrapped_reg, wrapped_next;

    logic              go;
    logic [15:0]       phase_inc;
    logic [31:0]       start_nb;
    logic [SLOT_W-1:0] wr;

    always_comb
    begin
        enabled_next       = enabled_reg;
        phase_next         = phase_reg;
        not_before_next    = not_before_reg;
        wait_busy_next     = wait_busy_reg;
        busy_seen_next     = busy_seen_reg;
        reset_on_busy_next = reset_on_busy_reg;
        duration_next      = duration_reg;
        deadline_next      = deadline_reg;
        slot_next          = slot_reg;
        wrapped_next       = wrapped_reg;
        go                 = 1'b0;
        phase_inc          = phase_reg + 16'd1;
        start_nb           = beat.now_ms + 32'(sat_time(cfg.start_delay));
        wr                 = slot_reg;
        result             = '0;

        case (beat.opcode)
            OP_START:
            begin
                slot_next       = '0;
                wrapped_next    = 1'b0;
                phase_next      = 16'd0;
                not_before_next = start_nb;
                wait_busy_next  = cfg.start_on_busy;
                duration_next   = sat_time(cfg.capture_duration);
                enabled_next    = 1'b1;
                if (cfg.start_on_busy)
                begin
                    // Armed now only if the trigger condition already holds.
                    busy_seen_next     = beat.busy_now;
                    reset_on_busy_next = !beat.busy_now;
                    deadline_next      = (beat.busy_now && (duration_next != 19'd0))
                                         ? start_nb + 32'(duration_next) : 32'd0;
                end
                else
                begin
                    busy_seen_next     = 1'b1;
                    reset_on_busy_next = 1'b0;
                    deadline_next      = (duration_next != 19'd0)
                                         ? start_nb + 32'(duration_next) : 32'd0;
                end
            end
            OP_STOP:
            begin
                enabled_next       = 1'b0;
                wait_busy_next     = 1'b0;
                busy_seen_next     = 1'b0;
                reset_on_busy_next = 1'b0;
                duration_next      = 19'd0;
                deadline_next      = 32'd0;
            end
            OP_BUSY:
            begin
                if (enabled_reg && wait_busy_reg && !busy_seen_reg)
                begin
                    busy_seen_next = 1'b1;
                    if (reset_on_busy_reg)
                    begin
                        slot_next          = '0;
                        wrapped_next       = 1'b0;
                        phase_next         = 16'd0;
                        reset_on_busy_next = 1'b0;
                        if (duration_reg != 19'd0)
                        begin
                            deadline_next = beat.now_ms + 32'(duration_reg);
                        end
                    end
                end
            end
            OP_TICK:
            begin
                go = enabled_reg && (beat.now_ms >= not_before_reg)
                     && !(wait_busy_reg && !busy_seen_reg);
                if (go && (cfg.sample_divisor > 16'd1))
                begin
                    if (phase_inc < cfg.sample_divisor)
                    begin
                        phase_next = phase_inc;
                        go         = 1'b0;
                    end
                    else
                    begin
                        phase_next = 16'd0;
                    end
                end
                if (go && (deadline_reg != 32'd0) && (beat.now_ms >= deadline_reg))
                begin
                    enabled_next = 1'b0;
                    go           = 1'b0;
                end
                if (go && (slot_reg >= SLOT_FULL))
                begin
                    if (cfg.ring_mode)
                    begin
                        wrapped_next = 1'b1;
                        wr           = '0;
                    end
                    else
                    begin
                        enabled_next = 1'b0;
                        go           = 1'b0;
                    end
                end
                if (go)
                begin
                    slot_next                = wr + SLOT_W'(1);
                    result.write_valid       = 1'b1;
                    result.write_index       = 12'(wr);
                    result.sample_centiwatts = to_centiwatts(beat.power_mw);
                end
            end
            default:
            begin
                go = 1'b0;
            end
        endcase

        result.next_index = 13'(slot_next);
        result.wrapped    = wrapped_next;
        result.capturing  = enabled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg       <= 1'b0;
            phase_reg         <= 16'd0;
            not_before_reg    <= 32'd0;
            wait_busy_reg     <= 1'b0;
            busy_seen_reg     <= 1'b0;
            reset_on_busy_reg <= 1'b0;
            duration_reg      <= 19'd0;
            deadline_reg      <= 32'd0;
            slot_reg          <= '0;
            wrapped_reg       <= 1'b0;
        end
        else if (step)
        begin
            enabled_reg       <= enabled_next;
            phase_reg         <= phase_next;
            not_before_reg    <= not_before_next;
            wait_busy_reg     <= wait_busy_next;
            busy_seen_reg     <= busy_seen_next;
            reset_on_busy_reg <= reset_on_busy_next;
            duration_reg      <= duration_next;
            deadline_reg      <= deadline_next;
            slot_reg          <= slot_next;
            wrapped_reg       <= wrapped_next;
        end
    end

`ifndef SYNTHESIS
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_FULL)
        else $error("write slot ran past the end of the store");

    a_write_while_on: assert property (@(posedge clk) disable iff (!rst_n)
        result.write_valid |-> (result.capturing && (beat.opcode == OP_TICK)))
        else $error("sample write without an enabled tick");

    a_stop_disables: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (beat.opcode == OP_STOP)) |=> (!enabled_reg && (deadline_reg == 32'd0)))
        else $error("stop did not end capture");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !result.write_valid |-> ((result.write_index == 12'd0)
                                 && (result.sample_centiwatts == 16'd0)))
        else $error("write fields not cleared on a beat without a write");
`endif

endmodule
`default_nettype wire

### rtl/power_trace_capture_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Power trace capture sequencer
// Sequences the capture of a power trace into an external sample store.
// ----------------------------------------------------------------------------
// Usage:
// Operation beats (tick, start, stop, busy trigger) arrive on the in channel;
// every beat yields exactly one result beat on the out channel, in order,
// carrying the store write (if any), the next index, the wrapped flag and
// whether capture is still enabled. Settings are written through the cfg
// channel, which is always ready; write it only while the block is drained.
// Pipeline: one register stage holds the accepted beat, the result register
// holds the answer, and the capture state updates as the beat moves between
// them, so the block sustains one beat per cycle while out_ready is high. A
// beat reaches out by way of the input stage and then the result register.
// When the receiver stalls, the result register holds its beat and the input
// stage can still take one more beat; after that in_ready drops until the
// result is taken. Asynchronous reset empties both stages, clears all capture
// state and returns the settings to their defaults (divisor one, others zero).
// ----------------------------------------------------------------------------
module power_trace_capture_sequencer_top
    import ptcs_pkg::*;
#(
    parameter int unsigned SAMPLE_COUNT = SAMPLE_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_beat_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_beat_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic      s1_valid_reg;
    in_beat_t  s1_beat_reg;
    logic      out_valid_reg;
    out_beat_t out_beat_reg;
    cfg_t      cfg_reg;
    out_beat_t result;
    logic      advance;

    // The held beat moves on whenever the result register is free or emptying.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;
    assign cfg_ready = 1'b1;

    ptcs_core #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .beat   (s1_beat_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_beat_reg <= in_data;
        end
        if (advance)
        begin
            out_beat_reg <= result;
        end
    end

    // Settings. Time settings saturate at the cap on write; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{start_delay: 19'd0, start_on_busy: 1'b0,
                         capture_duration: 19'd0, sample_divisor: 16'd1,
                         ring_mode: 1'b0};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_DELAY:      cfg_reg.start_delay      <= sat_time(cfg_data[18:0]);
                REG_START_ON_BUSY:    cfg_reg.start_on_busy    <= cfg_data[0];
                REG_CAPTURE_DURATION: cfg_reg.capture_duration <= sat_time(cfg_data[18:0]);
                REG_SAMPLE_DIVISOR:   cfg_reg.sample_divisor   <= cfg_data[15:0];
                REG_RING_MODE:        cfg_reg.ring_mode        <= cfg_data[0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat did not reach the result register");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while both stages are full");

    a_time_caps: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_reg.start_delay <= TIME_CAP) && (cfg_reg.capture_duration <= TIME_CAP))
        else $error("time setting above its cap");
`endif

endmodule
`default_nettype wire
